FILE: src/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define LPBQ_ASSERT_NOW(label, clk, rst_n, cond, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (rhs)) \
        else $error("lpbq check failed");

// Next-cycle implication, ignored while reset is held.
`define LPBQ_ASSERT_NEXT(label, clk, rst_n, cond, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (rhs)) \
        else $error("lpbq check failed");

// Next-cycle implication that is also checked through reset.
`define LPBQ_ASSERT_NEXT_ALWAYS(label, clk, cond, rhs) \
    label: assert property (@(posedge clk) (cond) |=> (rhs)) \
        else $error("lpbq check failed");

`endif

FILE: src/lpbq_pkg.sv
package lpbq_pkg;

    localparam int CFG_INDEX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER_MODE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING_ALPHA = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_B0         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_B1         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_B2         = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_A1         = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_A2         = 3'd6;

    // Filter modes.
    localparam logic MODE_FIRST_ORDER = 1'b0;
    localparam logic MODE_BIQUAD      = 1'b1;

endpackage

FILE: src/lpbq_cfg_regs.sv
module lpbq_cfg_regs #(
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic [lpbq_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]               cfg_data,
    output logic                                    order_mode,
    output logic [COEF_FRAC_BITS-1:0]               smoothing_alpha,
    output logic signed [COEF_FRAC_BITS+1:0]        coef_b0,
    output logic signed [COEF_FRAC_BITS+1:0]        coef_b1,
    output logic signed [COEF_FRAC_BITS+1:0]        coef_b2,
    output logic signed [COEF_FRAC_BITS+1:0]        coef_a1,
    output logic signed [COEF_FRAC_BITS+1:0]        coef_a2
);
    import lpbq_pkg::*;

    localparam int CB = COEF_FRAC_BITS + 2;
    localparam logic [COEF_FRAC_BITS-1:0] ALPHA_RESET =
        COEF_FRAC_BITS'(1) << (COEF_FRAC_BITS - 1);

    logic                   order_mode_reg;
    logic [COEF_FRAC_BITS-1:0] alpha_reg;
    logic [CB-1:0]          b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= MODE_BIQUAD;
            alpha_reg      <= ALPHA_RESET;
            b0_reg         <= '0;
            b1_reg         <= '0;
            b2_reg         <= '0;
            a1_reg         <= '0;
            a2_reg         <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORDER_MODE:      order_mode_reg <= cfg_data[0];
                REG_SMOOTHING_ALPHA: alpha_reg      <= cfg_data[COEF_FRAC_BITS-1:0];
                REG_COEF_B0:         b0_reg         <= cfg_data;
                REG_COEF_B1:         b1_reg         <= cfg_data;
                REG_COEF_B2:         b2_reg         <= cfg_data;
                REG_COEF_A1:         a1_reg         <= cfg_data;
                REG_COEF_A2:         a2_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    assign order_mode      = order_mode_reg;
    assign smoothing_alpha = alpha_reg;
    assign coef_b0         = $signed(b0_reg);
    assign coef_b1         = $signed(b1_reg);
    assign coef_b2         = $signed(b2_reg);
    assign coef_a1         = $signed(a1_reg);
    assign coef_a2         = $signed(a2_reg);

endmodule

FILE: src/lpbq_core.sv
module lpbq_core #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     x_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]     y_sample,
    output logic                              clipped,
    input  logic                              order_mode,
    input  logic [COEF_FRAC_BITS-1:0]         smoothing_alpha,
    input  logic signed [COEF_FRAC_BITS+1:0]  coef_b0,
    input  logic signed [COEF_FRAC_BITS+1:0]  coef_b1,
    input  logic signed [COEF_FRAC_BITS+1:0]  coef_b2,
    input  logic signed [COEF_FRAC_BITS+1:0]  coef_a1,
    input  logic signed [COEF_FRAC_BITS+1:0]  coef_a2
);
    import lpbq_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int F  = COEF_FRAC_BITS;
    localparam int CB = F + 2;
    localparam int MW = CB + S;      // full product
    localparam int PW = MW + 1;      // product plus rounding constant
    localparam int TW = PW - F;      // one rounded term
    localparam int AW = TW + 3;      // sum of five terms
    localparam int NT = 5;

    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (F - 1);
    localparam logic signed [CB-1:0] ONE_Q    = CB'(1) <<< F;
    localparam logic signed [AW-1:0] SAT_MAX  = (AW'(1) <<< (S - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SAT_MIN  = -SAT_MAX - AW'(1);

    logic                  in_valid_reg, in_valid_next;
    logic signed [S-1:0]   x_reg;
    logic                  out_valid_reg, out_valid_next;
    logic signed [S-1:0]   y_reg;
    logic                  clip_reg;
    logic signed [S-1:0]   in_hist1_reg, in_hist2_reg, out_hist1_reg, out_hist2_reg;

    logic                  take_in;
    logic                  advance;
    logic signed [CB-1:0]  coef [NT];
    logic signed [S-1:0]   samp [NT];
    logic signed [MW-1:0]  prod [NT];
    logic signed [PW-1:0]  rnd  [NT];
    logic signed [TW-1:0]  term [NT];
    logic signed [AW-1:0]  acc;
    logic signed [S-1:0]   y_sat;
    logic                  clip_sat;

    // The result register frees up in the same cycle it is drained.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign take_in  = in_valid && in_ready;

    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    // First-order mode reuses the x lane for alpha and the y1 lane for 1 - alpha.
    always_comb begin
        if (order_mode == MODE_BIQUAD) begin
            coef[0] = coef_b0;
            coef[3] = coef_a1;
        end else begin
            coef[0] = $signed({2'b00, smoothing_alpha});
            coef[3] = ONE_Q - $signed({2'b00, smoothing_alpha});
        end
        coef[1] = coef_b1;
        coef[2] = coef_b2;
        coef[4] = coef_a2;
        samp[0] = x_reg;
        samp[1] = in_hist1_reg;
        samp[2] = in_hist2_reg;
        samp[3] = out_hist1_reg;
        samp[4] = out_hist2_reg;
    end

    // Each product is rounded on its own: add half an LSB, then floor.
    always_comb begin
        for (int i = 0; i < NT; i++) begin
            prod[i] = coef[i] * samp[i];
            rnd[i]  = PW'(prod[i]) + HALF_LSB;
            term[i] = $signed(rnd[i][PW-1:F]);
        end
    end

    always_comb begin
        if (order_mode == MODE_BIQUAD) begin
            acc = AW'(term[0]) + AW'(term[1]) + AW'(term[2])
                - AW'(term[3]) - AW'(term[4]);
        end else begin
            acc = AW'(term[0]) + AW'(term[3]);
        end
        if (acc > SAT_MAX) begin
            y_sat    = S'(SAT_MAX);
            clip_sat = 1'b1;
        end else if (acc < SAT_MIN) begin
            y_sat    = S'(SAT_MIN);
            clip_sat = 1'b1;
        end else begin
            y_sat    = acc[S-1:0];
            clip_sat = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_hist1_reg  <= '0;
            in_hist2_reg  <= '0;
            out_hist1_reg <= '0;
            out_hist2_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                out_hist1_reg <= y_sat;
                if (order_mode == MODE_BIQUAD) begin
                    in_hist1_reg  <= x_reg;
                    in_hist2_reg  <= in_hist1_reg;
                    out_hist2_reg <= out_hist1_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            x_reg <= x_sample;
        end
        if (advance) begin
            y_reg    <= y_sat;
            clip_reg <= clip_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign y_sample  = y_reg;
    assign clipped   = clip_reg;

endmodule

FILE: src/lowpass_biquad_or_first_order_top.sv
// Low-pass filter: one signed sample in, one filtered and saturated sample out, either a
// first-order smoother (y = alpha*x + (1-alpha)*y1) or a direct form I biquad, picked by
// register 0. A sample is taken on every cycle while the output is drained, and moves from
// the input register to the result register. The rate is set by the feedback loop: five
// multipliers, a sum of five terms (two in first-order mode) and the saturation sit between
// the input register and the result register, and the output histories are written at the
// same edge as the result. Coefficients are written over the cfg channel (index 0 mode, 1
// alpha Q0.F, 2..6 b0, b1, b2, a1, a2 in signed Q2.F); the user must write them only while
// no sample is in flight, unchecked; histories survive mode changes, cleared only by reset.
module lowpass_biquad_or_first_order_top #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // x_sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // y_sample
    output logic [0:0]                            m_tuser,   // clipped
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lpbq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]             cfg_data
);
    import lpbq_pkg::*;

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    logic                              order_mode;
    logic [COEF_FRAC_BITS-1:0]         smoothing_alpha;
    logic signed [COEF_FRAC_BITS+1:0]  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic signed [SAMPLE_BITS-1:0]     y_sample;
    logic                              clipped;

    assign cfg_ready = 1'b1;

    lpbq_cfg_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .order_mode      (order_mode),
        .smoothing_alpha (smoothing_alpha),
        .coef_b0         (coef_b0),
        .coef_b1         (coef_b1),
        .coef_b2         (coef_b2),
        .coef_a1         (coef_a1),
        .coef_a2         (coef_a2)
    );

    lpbq_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .x_sample        ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .y_sample        (y_sample),
        .clipped         (clipped),
        .order_mode      (order_mode),
        .smoothing_alpha (smoothing_alpha),
        .coef_b0         (coef_b0),
        .coef_b1         (coef_b1),
        .coef_b2         (coef_b2),
        .coef_a1         (coef_a1),
        .coef_a2         (coef_a2)
    );

    assign m_tdata = TDATA_BITS'($unsigned(y_sample));
    assign m_tuser = clipped;

endmodule

FILE: src/lpbq_checker.sv
`include "assert_macros.svh"

module lpbq_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,
    input logic [0:0]                        m_tuser
);
    localparam logic [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic y_on_rail;
    logic held;

    assign y_on_rail = (m_tdata[SAMPLE_BITS-1:0] == Y_MAX) ||
                       (m_tdata[SAMPLE_BITS-1:0] == Y_MIN);
    assign held      = m_tvalid && !m_tready;

    // A clipped result must sit on one of the two rails.
    `LPBQ_ASSERT_NOW(a_clip_on_rail, aclk, aresetn, m_tvalid && m_tuser[0], y_on_rail)

    // The input side only stalls while a finished result is held back.
    `LPBQ_ASSERT_NOW(a_stall_only_on_backpressure, aclk, aresetn, !s_tready, held)

    // A result that is not taken stays put.
    `LPBQ_ASSERT_NEXT(a_result_holds, aclk, aresetn, held, m_tvalid && $stable({m_tdata, m_tuser}))

    // Reset empties the pipeline.
    `LPBQ_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind lowpass_biquad_or_first_order_top lpbq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lpbq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
